FILE: src/segment_triangle_intersect_macros.svh
// Assertion macros for the segment/triangle intersection block.
// Used by segment_triangle_intersect.sv; expects clk and arst_n in scope.
`ifndef SEGMENT_TRIANGLE_INTERSECT_MACROS_SVH
`define SEGMENT_TRIANGLE_INTERSECT_MACROS_SVH
`ifndef SYNTHESIS
`define STI_CHECK(label, expr, msg) label: assert property (@(posedge clk) \
	disable iff (!arst_n) (expr)) else $error(msg);
`define STI_IMPLY(label, cond, expr, msg) label: assert property (@(posedge clk) \
	disable iff (!arst_n) (cond) |-> (expr)) else $error(msg);
`else
`define STI_CHECK(label, expr, msg)
`define STI_IMPLY(label, cond, expr, msg)
`endif
`endif

FILE: src/sti_pkg.sv
// Shared widths and register codes for the segment/triangle intersection block.
// No dependencies; imported by segment_triangle_intersect.
`timescale 1ns / 1ps
`default_nettype none
package sti_pkg;
	localparam int CRD_W  = 32;   // input coordinate
	localparam int DIF_W  = 33;   // coordinate difference
	localparam int CRS_W  = 67;   // cross product component
	localparam int LO_W   = 34;   // low slice of a cross component
	localparam int PRD_W  = 100;  // one term of a dot product
	localparam int VOL_W  = 102;  // signed volume
	localparam int CHK_W  = 34;   // slice of the numerator magnitude
	localparam int NCHK   = 3;    // slices of the numerator magnitude
	localparam int PM_W   = VOL_W + DIF_W;  // |num * d|
	localparam int NUM_W  = PM_W + 2;       // dividend 2|P| + |D|
	localparam int DEN_W  = VOL_W + 1;      // divisor 2|D|
	localparam int QUO_W  = 32;             // rounded offset magnitude
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_START_Z = 2'd2;
endpackage
`default_nettype wire

FILE: src/sti_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Stand-alone; instantiated per axis by segment_triangle_intersect.
`timescale 1ns / 1ps
`default_nettype none
module sti_divider #(
	parameter int NW = 137,
	parameter int DW = 103,
	parameter int QB = 32
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QB-1:0] quo
);
	logic [NW-1:0] rem_q [QB-1];
	logic [DW-1:0] dv_q  [QB-1];
	logic [QB-1:0] q_q   [QB];

	logic [NW-1:0] rin  [QB];
	logic [DW-1:0] din  [QB];
	logic [QB-1:0] qin  [QB];
	logic [NW-1:0] rnx  [QB];
	logic [QB-1:0] qnx  [QB];

	always_comb begin
		rin[0] = num;
		din[0] = den;
		qin[0] = '0;
		for (int k = 1; k < QB; k++) begin
			rin[k] = rem_q[k-1];
			din[k] = dv_q[k-1];
			qin[k] = q_q[k-1];
		end
		for (int k = 0; k < QB; k++) begin
			// trial subtract of the divisor aligned to this quotient bit
			if (rin[k] >= ({{(NW-DW){1'b0}}, din[k]} << (QB-1-k))) begin
				rnx[k] = rin[k] - ({{(NW-DW){1'b0}}, din[k]} << (QB-1-k));
				qnx[k] = qin[k] | ({{(QB-1){1'b0}}, 1'b1} << (QB-1-k));
			end else begin
				rnx[k] = rin[k];
				qnx[k] = qin[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB-1; k++) begin
				rem_q[k] <= rnx[k];
				dv_q[k]  <= din[k];
			end
			for (int k = 0; k < QB; k++) begin
				q_q[k] <= qnx[k];
			end
		end
	end

	assign quo = q_q[QB-1];
endmodule
`default_nettype wire

FILE: src/segment_triangle_intersect.sv
// Segment/triangle intersection top level: pipeline, skid output, APB registers.
// Depends on sti_pkg, sti_divider and segment_triangle_intersect_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   The segment start S (camera position) sits in three APB registers,
//   start_x/y/z at byte addresses 0, 4 and 8; write them only while the
//   block is empty. Each input transfer carries the segment end E and the
//   triangle vertices A, B, C; each one yields exactly one output transfer
//   with hit and the intersection point (zero when there is no hit).
//   A transfer happens on a rising edge with valid high and stall low.
//   Throughput: one item per cycle while in_stall is low. Path from input
//   transfer to out_valid: 11 arithmetic stages, 32 divider stages, one
//   sign, offset and saturate stage, the output register. The divider
//   stages are the per-axis divider, which resolves one quotient bit per stage.
//   Stall: a two-entry output (register plus skid) absorbs a result that
//   arrives while the receiver stalls; in_stall is high while the skid
//   entry is full, and the whole pipeline holds until it drains.
//   Reset: all valid bits clear and start_x/y/z return to zero.
//   The hit test is exact: all volumes are full-width integers.
module segment_triangle_intersect (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [sti_pkg::ADDR_W-1:0]          paddr,
	input  wire logic [sti_pkg::DATA_W-1:0]          pwdata,
	output logic      [sti_pkg::DATA_W-1:0]          prdata,
	output logic                                     pready,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    end_x,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    end_y,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    end_z,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    va_x,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    va_y,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    va_z,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    vb_x,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    vb_y,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    vb_z,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    vc_x,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    vc_y,
	input  wire logic signed [sti_pkg::CRD_W-1:0]    vc_z,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     hit,
	output logic signed [sti_pkg::CRD_W-1:0]         hit_x,
	output logic signed [sti_pkg::CRD_W-1:0]         hit_y,
	output logic signed [sti_pkg::CRD_W-1:0]         hit_z
);
	import sti_pkg::*;
`include "segment_triangle_intersect_macros.svh"

	// index of the next and the one after, per vector component
	localparam int NX1 [3] = '{1, 2, 0};
	localparam int NX2 [3] = '{2, 0, 1};

	// ---------------- configuration ----------------
	logic signed [CRD_W-1:0] start_q [3];
	logic                    wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) start_q[i] <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_START_X: start_q[0] <= pwdata;
				REG_START_Y: start_q[1] <= pwdata;
				REG_START_Z: start_q[2] <= pwdata;
				default: ;  // beyond the register list: drop
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_START_X: prdata = start_q[0];
			REG_START_Y: prdata = start_q[1];
			REG_START_Z: prdata = start_q[2];
			default:     prdata = '0;
		endcase
	end

	// ---------------- flow control ----------------
	// The pipeline advances whenever the skid entry is empty, so the
	// input side never waits on the receiver's combinational stall.
	logic en;
	logic k_v_q;
	assign en       = !k_v_q;
	assign in_stall = !en;

	// ---------------- input staging ----------------
	logic signed [CRD_W-1:0] e_in [3];
	logic signed [CRD_W-1:0] p_in [3][3];

	always_comb begin
		e_in[0] = end_x;  e_in[1] = end_y;  e_in[2] = end_z;
		p_in[0][0] = va_x; p_in[0][1] = va_y; p_in[0][2] = va_z;
		p_in[1][0] = vb_x; p_in[1][1] = vb_y; p_in[1][2] = vb_z;
		p_in[2][0] = vc_x; p_in[2][1] = vc_y; p_in[2][2] = vc_z;
	end

	// Stage 1: everything relative to S. a, b, c are the vertices, d = E - S.
	logic signed [DIF_W-1:0] pt_s1 [3][3];
	logic signed [DIF_W-1:0] d_s1  [3];
	// Stage 2: cross product terms for a x b, b x c, c x a.
	logic signed [2*DIF_W-1:0] pp_s2 [3][3][2];
	logic signed [DIF_W-1:0]   a_s2  [3];
	logic signed [DIF_W-1:0]   d_s2  [3];
	// Stage 3: cross products.
	logic signed [CRS_W-1:0] cr_s3 [3][3];
	logic signed [DIF_W-1:0] a_s3  [3];
	logic signed [DIF_W-1:0] d_s3  [3];
	// Stage 4: dot product slices. Dots 0..2 are d.(axb), d.(bxc), d.(cxa),
	// dot 3 is a.(bxc), the volume of S against the triangle.
	logic signed [LO_W+DIF_W:0]   lo_s4 [4][3];
	logic signed [CRS_W-LO_W+DIF_W-1:0] hi_s4 [4][3];
	logic signed [DIF_W-1:0]      d_s4  [3];
	// Stage 5: dot product terms.
	logic signed [PRD_W-1:0] tm_s5 [4][3];
	logic signed [DIF_W-1:0] d_s5  [3];
	// Stage 6: volumes.
	logic signed [VOL_W-1:0] vol_s6 [4];
	logic signed [DIF_W-1:0] d_s6   [3];
	// Stage 7: denominator (E-S).n, numerator is V1.
	logic signed [VOL_W-1:0] num_s7;
	logic signed [VOL_W-1:0] den_s7;
	logic                    p1_s7, p3_s7, p4_s7, p5_s7;
	logic signed [DIF_W-1:0] d_s7   [3];
	// Stage 8: hit decision and magnitudes.
	logic                    hit_s8;
	logic [VOL_W-1:0]        nmag_s8;
	logic [VOL_W-1:0]        dmag_s8;
	logic [DIF_W-1:0]        amag_s8 [3];
	logic [2:0]              neg_s8;
	// Stage 9: slices of |num| * |d_i|.
	logic [CHK_W+DIF_W-1:0]  mp_s9 [3][NCHK];
	logic [VOL_W-1:0]        dmag_s9;
	logic                    hit_s9;
	logic [2:0]              neg_s9;
	// Stage 10: |num * d_i|.
	logic [PM_W-1:0]         pm_s10 [3];
	logic [VOL_W-1:0]        dmag_s10;
	logic                    hit_s10;
	logic [2:0]              neg_s10;
	// Stage 11: dividend and divisor for round-half-away division.
	logic [NUM_W-1:0]        nd_s11 [3];
	logic [DEN_W-1:0]        dv_s11;
	logic                    hit_s11;
	logic [2:0]              neg_s11;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	// sideband that rides alongside the divider stages
	logic             side_v_q   [QUO_W];
	logic             side_hit_q [QUO_W];
	logic [2:0]       side_neg_q [QUO_W];

	logic [QUO_W-1:0] quo [3];

	// final stage
	logic                    v_s12;
	logic                    hit_s12;
	logic signed [CRD_W-1:0] pt_s12 [3];

	// combinational helpers for stages 7 and 8
	logic signed [VOL_W-1:0] v2_c;
	logic signed [VOL_W-1:0] den_c;

	function automatic logic is_pos(input logic signed [VOL_W-1:0] v);
		return !v[VOL_W-1] && (v != '0);
	endfunction

	assign den_c = vol_s6[0] + vol_s6[1] + vol_s6[2];
	assign v2_c  = num_s7 - den_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DIF_W'(e_in[i]) - DIF_W'(start_q[i]);
				for (int p = 0; p < 3; p++)
					pt_s1[p][i] <= DIF_W'(p_in[p][i]) - DIF_W'(start_q[i]);
			end
			// stage 2: cross x takes point x and the next point
			for (int x = 0; x < 3; x++) begin
				for (int j = 0; j < 3; j++) begin
					pp_s2[x][j][0] <= pt_s1[x][NX1[j]] * pt_s1[NX1[x]][NX2[j]];
					pp_s2[x][j][1] <= pt_s1[x][NX2[j]] * pt_s1[NX1[x]][NX1[j]];
				end
			end
			a_s2 <= pt_s1[0];
			d_s2 <= d_s1;
			// stage 3
			for (int x = 0; x < 3; x++)
				for (int j = 0; j < 3; j++)
					cr_s3[x][j] <= CRS_W'(pp_s2[x][j][0]) - CRS_W'(pp_s2[x][j][1]);
			a_s3 <= a_s2;
			d_s3 <= d_s2;
			// stage 4: split each cross component into low and high slices
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					lo_s4[k][j] <= $signed({1'b0, cr_s3[k][j][LO_W-1:0]}) * d_s3[j];
					hi_s4[k][j] <= $signed(cr_s3[k][j][CRS_W-1:LO_W]) * d_s3[j];
				end
			end
			for (int j = 0; j < 3; j++) begin
				lo_s4[3][j] <= $signed({1'b0, cr_s3[1][j][LO_W-1:0]}) * a_s3[j];
				hi_s4[3][j] <= $signed(cr_s3[1][j][CRS_W-1:LO_W]) * a_s3[j];
			end
			d_s4 <= d_s3;
			// stage 5
			for (int k = 0; k < 4; k++)
				for (int j = 0; j < 3; j++)
					tm_s5[k][j] <= PRD_W'(lo_s4[k][j]) + (PRD_W'(hi_s4[k][j]) <<< LO_W);
			d_s5 <= d_s4;
			// stage 6
			for (int k = 0; k < 4; k++)
				vol_s6[k] <= VOL_W'(tm_s5[k][0]) + VOL_W'(tm_s5[k][1])
					+ VOL_W'(tm_s5[k][2]);
			d_s6 <= d_s5;
			// stage 7: V3..V5 share a sign for a crossing inside all edges
			num_s7 <= vol_s6[3];
			den_s7 <= den_c;
			p1_s7  <= is_pos(vol_s6[3]);
			p3_s7  <= is_pos(vol_s6[0]);
			p4_s7  <= is_pos(vol_s6[1]);
			p5_s7  <= is_pos(vol_s6[2]);
			d_s7   <= d_s6;
			// stage 8: V2 = V1 - den; ends on opposite sides of the plane
			hit_s8  <= (p1_s7 != is_pos(v2_c)) && (p3_s7 == p4_s7) && (p4_s7 == p5_s7);
			nmag_s8 <= num_s7[VOL_W-1] ? VOL_W'(-num_s7) : VOL_W'(num_s7);
			dmag_s8 <= den_s7[VOL_W-1] ? VOL_W'(-den_s7) : VOL_W'(den_s7);
			for (int i = 0; i < 3; i++) begin
				amag_s8[i] <= d_s7[i][DIF_W-1] ? DIF_W'(-d_s7[i]) : DIF_W'(d_s7[i]);
				neg_s8[i]  <= num_s7[VOL_W-1] ^ d_s7[i][DIF_W-1] ^ den_s7[VOL_W-1];
			end
			// stage 9
			for (int i = 0; i < 3; i++)
				for (int c = 0; c < NCHK; c++)
					mp_s9[i][c] <= (CHK_W+DIF_W)'(nmag_s8[c*CHK_W +: CHK_W])
						* (CHK_W+DIF_W)'(amag_s8[i]);
			dmag_s9 <= dmag_s8;
			hit_s9  <= hit_s8;
			neg_s9  <= neg_s8;
			// stage 10
			for (int i = 0; i < 3; i++)
				pm_s10[i] <= PM_W'(mp_s9[i][0]) + (PM_W'(mp_s9[i][1]) << CHK_W)
					+ (PM_W'(mp_s9[i][2]) << (2*CHK_W));
			dmag_s10 <= dmag_s9;
			hit_s10  <= hit_s9;
			neg_s10  <= neg_s9;
			// stage 11: round(P/D) = floor((2P + D) / 2D)
			for (int i = 0; i < 3; i++)
				nd_s11[i] <= {1'b0, pm_s10[i], 1'b0} + NUM_W'(dmag_s10);
			dv_s11  <= {dmag_s10, 1'b0};
			hit_s11 <= hit_s10;
			neg_s11 <= neg_s10;
			// divider sideband
			side_hit_q[0] <= hit_s11;
			side_neg_q[0] <= neg_s11;
			for (int k = 1; k < QUO_W; k++) begin
				side_hit_q[k] <= side_hit_q[k-1];
				side_neg_q[k] <= side_neg_q[k-1];
			end
		end
	end

	// ---------------- dividers ----------------
	for (genvar g = 0; g < 3; g++) begin : g_div
		sti_divider #(
			.NW (NUM_W),
			.DW (DEN_W),
			.QB (QUO_W)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (nd_s11[g]),
			.den (dv_s11),
			.quo (quo[g])
		);
	end

	// ---------------- final stage: sign, offset from S, saturate ----------------
	logic signed [CRD_W+2:0] sum_c [3];
	logic signed [CRD_W-1:0] sat_c [3];

	localparam logic signed [CRD_W+2:0] SAT_HI = (CRD_W+3)'({1'b0, {(CRD_W-1){1'b1}}});
	localparam logic signed [CRD_W+2:0] SAT_LO = -SAT_HI - 1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (side_neg_q[QUO_W-1][i])
				sum_c[i] = (CRD_W+3)'(start_q[i]) - $signed({3'b000, quo[i]});
			else
				sum_c[i] = (CRD_W+3)'(start_q[i]) + $signed({3'b000, quo[i]});
			if (sum_c[i] > SAT_HI)
				sat_c[i] = SAT_HI[CRD_W-1:0];
			else if (sum_c[i] < SAT_LO)
				sat_c[i] = SAT_LO[CRD_W-1:0];
			else
				sat_c[i] = sum_c[i][CRD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s12 <= side_hit_q[QUO_W-1];
			for (int i = 0; i < 3; i++)
				pt_s12[i] <= side_hit_q[QUO_W-1] ? sat_c[i] : '0;
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11, v_s12} <= '0;
			for (int k = 0; k < QUO_W; k++) side_v_q[k] <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			side_v_q[0] <= v_s11;
			for (int k = 1; k < QUO_W; k++) side_v_q[k] <= side_v_q[k-1];
			v_s12 <= side_v_q[QUO_W-1];
		end
	end

	// ---------------- output register and skid entry ----------------
	logic                    o_v_q;
	logic                    o_hit_q;
	logic signed [CRD_W-1:0] o_pt_q [3];
	logic                    k_hit_q;
	logic signed [CRD_W-1:0] k_pt_q [3];
	logic                    out_xfer;
	logic                    pop;

	assign out_xfer = o_v_q && !out_stall;
	assign pop      = en && v_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q <= 1'b0;
			k_v_q <= 1'b0;
		end else if (k_v_q) begin
			// pipeline held; drain the skid entry into the output register
			if (out_xfer) begin
				o_v_q <= 1'b1;
				k_v_q <= 1'b0;
			end
		end else if (pop) begin
			if (o_v_q && !out_xfer) k_v_q <= 1'b1;
			else                    o_v_q <= 1'b1;
		end else if (out_xfer) begin
			o_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (k_v_q) begin
			if (out_xfer) begin
				o_hit_q <= k_hit_q;
				o_pt_q  <= k_pt_q;
			end
		end else if (pop) begin
			if (o_v_q && !out_xfer) begin
				k_hit_q <= hit_s12;
				k_pt_q  <= pt_s12;
			end else begin
				o_hit_q <= hit_s12;
				o_pt_q  <= pt_s12;
			end
		end
	end

	assign out_valid = o_v_q;
	assign hit       = o_hit_q;
	assign hit_x     = o_pt_q[0];
	assign hit_y     = o_pt_q[1];
	assign hit_z     = o_pt_q[2];

	// ---------------- assertions ----------------
	`STI_IMPLY(a_skid_needs_out, k_v_q, o_v_q, "skid entry full while output register empty")
	`STI_IMPLY(a_skid_fill, $rose(k_v_q), $past(o_v_q && out_stall && v_s12), "skid filled without a stalled result")
	`STI_IMPLY(a_miss_zero, o_v_q && !o_hit_q, (o_pt_q[0] == '0) && (o_pt_q[1] == '0) && (o_pt_q[2] == '0), "miss result carries a nonzero point")
	`STI_IMPLY(a_hold_stage, k_v_q && $past(k_v_q) && v_s12, $stable(pt_s12[0]) && $stable(hit_s12), "final stage changed while held")
endmodule
`default_nettype wire
